// ===== rtl/assert_macros.svh =====
// Assertion macros for RTL files that carry concurrent checks; the top level includes them.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define FRP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/frp_pkg.sv =====
// Package for the framed relay: sizes, character codes, shared types and the hex helper.
// No dependencies; the port capture and the top level import it.
`timescale 1ns / 1ps

package frp_pkg;

    localparam int BODY_DEPTH  = 21;
    localparam int SEND_COPIES = 3;
    localparam int NUM_PORTS   = 6;
    localparam int FRAME_LEN   = 36;
    localparam int LAST_POS    = FRAME_LEN - 1;
    localparam int CHK_HI_POS  = 18;
    localparam int CHK_LO_POS  = 19;
    // Sweep far enough to cover the checksum span and both check digits.
    localparam int CHK_READS   = (BODY_DEPTH - 2 > CHK_LO_POS + 1) ? BODY_DEPTH - 2
                                                                   : CHK_LO_POS + 1;
    localparam int AW          = $clog2(BODY_DEPTH);
    localparam int LEN_W       = $clog2(BODY_DEPTH + 1);
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int COPY_W      = (SEND_COPIES > 1) ? $clog2(SEND_COPIES) : 1;
    localparam int MID_W       = 4;

    localparam logic [7:0] CH_HEAD = 8'h40;
    localparam logic [7:0] CH_TAIL = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NL   = 8'h0A;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_SERIAL = 2'd1;
    localparam logic [1:0] OP_LATCH  = 2'd2;

    localparam logic [MID_W-1:0] MID_RESET = 4'd1;

    typedef logic [NUM_PORTS-1:0][7:0] t_snap;

    typedef struct packed {
        logic sample;
        logic latch;
    } t_pc_ctl;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = 8'h41 + {4'd0, nib - 4'd10};
        end
        return r;
    endfunction

endpackage

// ===== rtl/frp_in_if.sv =====
// Input request channel of the framed relay: valid/ready plus one event's fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] port_a;
    logic [7:0] port_c;
    logic [7:0] port_l;
    logic [7:0] port_b;
    logic [7:0] port_f;
    logic [7:0] port_k;

    modport source (output valid, op, rx_byte, port_a, port_c, port_l, port_b, port_f,
                    port_k, input ready);
    modport sink   (input valid, op, rx_byte, port_a, port_c, port_l, port_b, port_f,
                    port_k, output ready);
endinterface

// ===== rtl/frp_out_if.sv =====
// Output request channel of the framed relay: valid/ready plus one pair of frame bytes.
// Depends on nothing.
`timescale 1ns / 1ps

interface frp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       last_pair;

    modport source (output valid, first_byte, second_byte, last_pair, input ready);
    modport sink   (input valid, first_byte, second_byte, last_pair, output ready);
endinterface

// ===== rtl/frp_port_capture.sv =====
// Port capture: OR-accumulates six port samples and latches them into snapshots.
// Depends on frp_pkg.
`timescale 1ns / 1ps

module frp_port_capture (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frp_pkg::t_pc_ctl i_ctl,
    input  frp_pkg::t_snap   i_ports,
    output frp_pkg::t_snap   o_snap
);
    import frp_pkg::*;

    t_snap r_acc;
    t_snap r_snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_snap <= '0;
        end else if (i_ctl.latch) begin
            r_snap <= r_acc;
            r_acc  <= '0;
        end else if (i_ctl.sample) begin
            r_acc <= r_acc | i_ports;
        end
    end

    assign o_snap = r_snap;

endmodule

// ===== rtl/framed_relay_with_port_capture_unit.sv =====
// Top level of the framed relay with port capture: deframer, body memory, frame sequencer.
// Depends on frp_pkg, frp_in_if, frp_out_if, frp_port_capture and assert_macros.svh.
`timescale 1ns / 1ps

// Usage:
//   i_in carries one event per request: op 0 ORs the six port levels into the
//   accumulators, op 1 delivers a serial byte, op 2 latches the accumulators into
//   the snapshots and clears them. Op 3 is ignored.
//   o_out carries the relayed frame, two bytes per request; last_pair marks the
//   final pair of the final copy. i_cfg_we/i_cfg_wdata write the machine id.
//   Port events and ordinary serial bytes are accepted back to back while idle.
//   A tail byte starts a check pass (one body memory read per cycle, the read
//   data registered before use) followed by a decide state. A good frame
//   then streams 3 copies of 18 pairs; each frame byte needs a memory read and
//   a capture, and the capture of a pair's second byte waits until the output
//   register is free. Input is held off while checking and sending.
//   The output register decouples the receiver: a pending pair stalls only the
//   sequencer, and the next tail may start checking before it is taken.
//   Reset (synchronous, active low) closes any frame, empties the body, clears
//   accumulators and snapshots, drops the output, and sets machine id to 1.
//   No clearing pass is needed: body entries at or beyond the fill count read
//   as zero.

module framed_relay_with_port_capture_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    frp_in_if.sink                    i_in,
    frp_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [frp_pkg::MID_W-1:0] i_cfg_wdata
);
    import frp_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHK      = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_EMIT_RD  = 3'd3;
    localparam logic [2:0] S_EMIT_CAP = 3'd4;

    // Body memory: written only from idle, read data used only while checking and
    // sending, so a write never meets a read whose data is used.
    logic [7:0] r_body [BODY_DEPTH];

    logic [2:0]        r_state, n_state;
    logic              r_in_frame, n_in_frame;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_rd_idx;
    logic [7:0]        r_rd_data;
    logic              r_chk_dv;
    logic [7:0]        r_xin, n_xin;
    logic [7:0]        r_xf, n_xf;
    logic [7:0]        r_b18, n_b18;
    logic [7:0]        r_b19, n_b19;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [COPY_W-1:0] r_copy, n_copy;
    logic [7:0]        r_first, n_first;
    logic              r_ov, n_ov;
    logic [7:0]        r_o_first, n_o_first;
    logic [7:0]        r_o_second, n_o_second;
    logic              r_o_last, n_o_last;
    logic [MID_W-1:0]  r_mid;

    logic           in_acc;
    logic           serial;
    logic           mem_we;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_val;
    logic           in_sum;
    logic [7:0]     digit;
    logic [7:0]     snap_x;
    logic [7:0]     cur_byte;
    logic           out_free;
    logic           last_byte;
    logic           last_copy;
    logic           send_end;
    logic           send_idle;
    t_snap          snap;
    t_snap          ports;
    t_pc_ctl        pc_ctl;

    // Body index that feeds a frame position; positions not fed from the body
    // map to entry zero and ignore the data.
    function automatic logic [AW-1:0] body_idx(input logic [POS_W-1:0] pos);
        logic [AW-1:0] r;
        r = '0;
        if (pos >= POS_W'(2) && pos <= POS_W'(13)) begin
            r = AW'(pos - POS_W'(1));
        end else if (pos == POS_W'(15)) begin
            r = AW'(13);
        end else if (pos >= POS_W'(28) && pos <= POS_W'(31)) begin
            r = AW'(pos - POS_W'(14));
        end
        return r;
    endfunction

    function automatic logic [7:0] frame_byte(
        input logic [POS_W-1:0] pos,
        input logic [7:0]       v,
        input logic [7:0]       dig,
        input t_snap            s,
        input logic [7:0]       xf
    );
        logic [7:0] r;
        case (pos)
            POS_W'(0):  r = CH_HEAD;
            POS_W'(1):  r = dig;
            POS_W'(14): r = hex_digit(s[0][3:0]);
            POS_W'(16): r = hex_digit(s[1][3:0]);
            POS_W'(17): r = hex_digit(s[0][7:4]);
            POS_W'(18): r = hex_digit(s[2][3:0]);
            POS_W'(19): r = hex_digit(s[1][7:4]);
            POS_W'(20): r = hex_digit(s[3][3:0]);
            POS_W'(21): r = hex_digit(s[2][7:4]);
            POS_W'(22): r = hex_digit(s[4][3:0]);
            POS_W'(23): r = hex_digit(s[3][7:4]);
            POS_W'(24): r = hex_digit(s[5][3:0]);
            POS_W'(25): r = hex_digit(s[4][7:4]);
            POS_W'(26): r = CH_ZERO;
            POS_W'(27): r = hex_digit(s[5][7:4]);
            POS_W'(32): r = hex_digit(xf[7:4]);
            POS_W'(33): r = hex_digit(xf[3:0]);
            POS_W'(34): r = CH_TAIL;
            POS_W'(35): r = CH_NL;
            default:    r = v;
        endcase
        return r;
    endfunction

    // Port capture lives in its own block; strobes come from accepted requests.
    assign ports = {i_in.port_k, i_in.port_f, i_in.port_b,
                    i_in.port_l, i_in.port_c, i_in.port_a};
    assign pc_ctl.sample = in_acc && (i_in.op == OP_SAMPLE);
    assign pc_ctl.latch  = in_acc && (i_in.op == OP_LATCH);

    frp_port_capture u_cap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pc_ctl),
        .i_ports (ports),
        .o_snap  (snap)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign serial     = in_acc && (i_in.op == OP_SERIAL);
    assign mem_we     = serial && r_in_frame && (i_in.rx_byte != CH_TAIL)
                        && (r_len < LEN_W'(BODY_DEPTH));

    // Read address: sweep counter while checking, frame position while sending.
    assign rd_addr = (r_state == S_CHK) ? r_cnt : body_idx(r_pos);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_body[r_len[AW-1:0]] <= i_in.rx_byte;
        end
        r_rd_data <= r_body[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    // Entries at or beyond the fill count read as zero.
    assign rd_val = (LEN_W'(r_rd_idx) < r_len) ? r_rd_data : 8'h00;
    assign in_sum = ((LEN_W + 1)'(r_rd_idx) + (LEN_W + 1)'(2)) < {1'b0, r_len};

    assign digit = CH_ZERO + {4'd0, (r_mid >= 4'd10) ? (r_mid - 4'd10) : r_mid};

    always_comb begin
        snap_x = CH_HEAD ^ digit ^ CH_ZERO;
        for (int i = 0; i < NUM_PORTS; i++) begin
            snap_x = snap_x ^ hex_digit(snap[i][3:0]) ^ hex_digit(snap[i][7:4]);
        end
    end

    assign cur_byte  = frame_byte(r_pos, rd_val, digit, snap, r_xf);
    assign out_free  = !r_ov || o_out.ready;
    assign last_byte = (r_pos == POS_W'(LAST_POS));
    assign last_copy = (r_copy == COPY_W'(SEND_COPIES - 1));

    always_comb begin
        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_xin      = r_xin;
        n_xf       = r_xf;
        n_b18      = r_b18;
        n_b19      = r_b19;
        n_pos      = r_pos;
        n_copy     = r_copy;
        n_first    = r_first;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_last   = r_o_last;
        n_ov       = r_ov && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (serial) begin
                    if (!r_in_frame) begin
                        // Open a frame on a header; drop anything else.
                        if (i_in.rx_byte == CH_HEAD) begin
                            n_in_frame = 1'b1;
                            n_len      = '0;
                        end
                    end else if (i_in.rx_byte == CH_TAIL) begin
                        // Close the frame and sweep the body.
                        n_in_frame = 1'b0;
                        n_cnt      = '0;
                        n_xin      = CH_HEAD;
                        n_xf       = 8'h00;
                        n_state    = S_CHK;
                    end else if (r_len >= LEN_W'(BODY_DEPTH)) begin
                        // Overlong body: abort and drop the byte.
                        n_in_frame = 1'b0;
                        n_len      = '0;
                    end else begin
                        n_len = r_len + LEN_W'(1);
                    end
                end
            end
            S_CHK: begin
                if (r_chk_dv) begin
                    if (in_sum) begin
                        n_xin = r_xin ^ rd_val;
                    end
                    if (r_rd_idx >= AW'(1) && r_rd_idx <= AW'(17)) begin
                        n_xf = r_xf ^ rd_val;
                    end
                    if (r_rd_idx == AW'(CHK_HI_POS)) begin
                        n_b18 = rd_val;
                    end
                    if (r_rd_idx == AW'(CHK_LO_POS)) begin
                        n_b19 = rd_val;
                    end
                end
                if (r_cnt == AW'(CHK_READS)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_DECIDE: begin
                if (hex_digit(r_xin[7:4]) == r_b18 && hex_digit(r_xin[3:0]) == r_b19) begin
                    n_xf    = r_xf ^ snap_x;
                    n_pos   = '0;
                    n_copy  = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_len   = '0;
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_CAP;
            end
            S_EMIT_CAP: begin
                if (!r_pos[0]) begin
                    n_first = cur_byte;
                    n_pos   = r_pos + POS_W'(1);
                    n_state = S_EMIT_RD;
                end else if (out_free) begin
                    // Hand the pair to the output register and advance.
                    n_ov       = 1'b1;
                    n_o_first  = r_first;
                    n_o_second = cur_byte;
                    n_o_last   = last_copy && last_byte;
                    if (last_byte) begin
                        n_pos = '0;
                        if (last_copy) begin
                            n_len   = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_copy  = r_copy + COPY_W'(1);
                            n_state = S_EMIT_RD;
                        end
                    end else begin
                        n_pos   = r_pos + POS_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_frame <= 1'b0;
            r_len      <= '0;
            r_cnt      <= '0;
            r_chk_dv   <= 1'b0;
            r_pos      <= '0;
            r_copy     <= '0;
            r_ov       <= 1'b0;
            r_mid      <= MID_RESET;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_len      <= n_len;
            r_cnt      <= n_cnt;
            r_chk_dv   <= (r_state == S_CHK) && (r_cnt < AW'(CHK_READS));
            r_pos      <= n_pos;
            r_copy     <= n_copy;
            r_ov       <= n_ov;
            if (i_cfg_we) begin
                r_mid <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_xin      <= n_xin;
        r_xf       <= n_xf;
        r_b18      <= n_b18;
        r_b19      <= n_b19;
        r_first    <= n_first;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_last   <= n_o_last;
    end

    assign o_out.valid       = r_ov;
    assign o_out.first_byte  = r_o_first;
    assign o_out.second_byte = r_o_second;
    assign o_out.last_pair   = r_o_last;

    // Final pair handed over, and the state that must follow it.
    assign send_end  = (r_state == S_EMIT_CAP) && r_pos[0] && out_free && last_byte
                       && last_copy;
    assign send_idle = (r_state == S_IDLE) && (r_len == '0) && r_ov && r_o_last;

    // Fill count never passes the body depth.
    `FRP_ASSERT_ALWAYS(a_len_bound, r_len <= LEN_W'(BODY_DEPTH), "body fill count overflow")
    // A frame is never open while the sequencer owns the body memory.
    `FRP_ASSERT_ALWAYS(a_frame_closed, (r_state == S_IDLE) || !r_in_frame, "frame open in send")
    // Handing over the final pair returns the block to idle with an empty body.
    `FRP_ASSERT_NEXT(a_last_idle, send_end, send_idle, "final pair did not end the send")

endmodule
